// ===== rtl/periodic_burst_step_selector_assert.svh =====
// Assertion macros for the periodic burst step selector checker.
`ifndef PERIODIC_BURST_STEP_SELECTOR_ASSERT_SVH
`define PERIODIC_BURST_STEP_SELECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PBSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbss_pkg.sv =====
// Shared widths and register indexes of the periodic burst step selector.
package pbss_pkg;

    localparam int STEP_W  = 31;
    localparam int WORD_W  = 32;
    localparam int CIDX_W  = 3;

    typedef enum logic [CIDX_W-1:0] {
        REG_START_STEP    = 3'd0,
        REG_END_STEP      = 3'd1,
        REG_PERIOD_LEN    = 3'd2,
        REG_BURST_SPACING = 3'd3,
        REG_BURST_WIDTH   = 3'd4
    } cfg_reg_t;

    localparam logic [STEP_W-1:0] NO_NEXT = {STEP_W{1'b1}};
    localparam logic [WORD_W-1:0] NO_PREV = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

// ===== rtl/pbss_rem_pipe.sv =====
// Pipelined restoring remainder unit: one quotient bit per stage.
module pbss_rem_pipe #(
    parameter int NUM_W  = 39,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [0:NUM_W-1];
    logic [NUM_W-1:0]  num_reg  [0:NUM_W-1];
    logic [DEN_W-1:0]  rem_reg  [0:NUM_W-1];
    logic [SIDE_W-1:0] side_reg [0:NUM_W-1];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic              vld_in;
            logic [NUM_W-1:0]  num_in;
            logic [DEN_W-1:0]  rem_in;
            logic [SIDE_W-1:0] side_in;
            logic [DEN_W:0]    trial;
            logic [DEN_W:0]    diff;
            logic [DEN_W-1:0]  rem_next;

            if (k == 0) begin : g_first
                assign vld_in  = in_valid;
                assign num_in  = num;
                assign rem_in  = '0;
                assign side_in = side;
            end else begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign num_in  = num_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign trial    = {rem_in, num_in[NUM_W-1-k]};
            assign diff     = trial - {1'b0, den};
            // borrow means trial < den, so trial fits
            assign rem_next = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[k]  <= num_in;
                    rem_reg[k]  <= rem_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NUM_W-1];
    assign out_num   = num_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

// ===== rtl/periodic_burst_step_selector.sv =====
// Periodic burst step selector: classifies timesteps against a windowed burst schedule.
// Each accepted timestep word yields one result word: selected, next_step and
// previous_step. The path is fully pipelined and takes one word per clock
// while the output register is free; the offset is reduced by two restoring
// remainder pipelines (offset mod period, then phase mod spacing), one bit per
// stage. The whole pipe advances together whenever the output register is empty
// or being taken, so a stall holds every stage. Registers are read live by all
// stages; write them only when the pipe is empty. A period or spacing of zero acts
// as one whole step. next_step saturates to 0x7FFFFFFF (none); previous_step uses
// 0x80000000 for none. cfg_ready is always high.
module periodic_burst_step_selector #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [30:0] timestep,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        selected,
    output logic [30:0] next_step,
    output logic [31:0] previous_step
);

    localparam int SW  = pbss_pkg::STEP_W;
    localparam int WW  = pbss_pkg::WORD_W;
    localparam int TW  = SW + FRAC_BITS;       // fixed-point offset width
    localparam int XW  = TW + 2;               // headroom for sums
    localparam logic [WW-1:0]        ONE    = WW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF_F = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [XW-1:0]        HALF_X = XW'(1) << (FRAC_BITS - 1);

    // configuration registers
    logic [SW-1:0] start_reg, end_reg;
    logic [WW-1:0] period_reg, spacing_reg, width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            end_reg     <= pbss_pkg::NO_NEXT;
            period_reg  <= ONE;
            spacing_reg <= ONE;
            width_reg   <= ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pbss_pkg::cfg_reg_t'(cfg_index))
                pbss_pkg::REG_START_STEP:    start_reg   <= cfg_data[SW-1:0];
                pbss_pkg::REG_END_STEP:      end_reg     <= cfg_data[SW-1:0];
                pbss_pkg::REG_PERIOD_LEN:    period_reg  <= cfg_data;
                pbss_pkg::REG_BURST_SPACING: spacing_reg <= cfg_data;
                pbss_pkg::REG_BURST_WIDTH:   width_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [WW-1:0] per_eff, spc_eff;
    assign per_eff = (period_reg  == '0) ? ONE : period_reg;
    assign spc_eff = (spacing_reg == '0) ? ONE : spacing_reg;

    // whole pipe moves when the output word is gone or leaving
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 0: fixed-point offset from window start, plus the half-step bias
    logic          s0_valid_reg;
    logic [SW-1:0] s0_ts_reg;
    logic [TW-1:0] s0_t_reg;
    logic [TW-1:0] s0_t_next;
    logic [SW-1:0] ts_diff;

    assign ts_diff   = timestep - start_reg;
    assign s0_t_next = (timestep >= start_reg) ? {ts_diff, HALF_F} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_ts_reg <= timestep;
            s0_t_reg  <= s0_t_next;
        end
    end

    // offset mod period -> phase within the period
    logic          d1_valid;
    logic [TW-1:0] d1_t;
    logic [WW-1:0] d1_phase;
    logic [SW-1:0] d1_ts;

    pbss_rem_pipe #(
        .NUM_W  (TW),
        .DEN_W  (WW),
        .SIDE_W (SW)
    ) u_period_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s0_valid_reg),
        .num       (s0_t_reg),
        .den       (per_eff),
        .side      (s0_ts_reg),
        .out_valid (d1_valid),
        .out_num   (d1_t),
        .out_rem   (d1_phase),
        .out_side  (d1_ts)
    );

    // phase mod spacing -> position within the current spacing slot
    logic             d2_valid;
    logic [WW-1:0]    d2_phase;
    logic [WW-1:0]    d2_slot;
    logic [SW+TW-1:0] d2_side;
    logic [SW-1:0]    d2_ts;
    logic [TW-1:0]    d2_t;

    pbss_rem_pipe #(
        .NUM_W  (WW),
        .DEN_W  (WW),
        .SIDE_W (SW + TW)
    ) u_spacing_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d1_valid),
        .num       (d1_phase),
        .den       (spc_eff),
        .side      ({d1_ts, d1_t}),
        .out_valid (d2_valid),
        .out_num   (d2_phase),
        .out_rem   (d2_slot),
        .out_side  (d2_side)
    );

    assign d2_ts = d2_side[SW+TW-1:TW];
    assign d2_t  = d2_side[TW-1:0];

    // final stage: window checks and rounding back to whole steps
    logic          ge_start, le_end, in_burst, hit;
    logic [XW-1:0] t_x, p_x, base_x, start_x;
    logic [XW-1:0] nxt_burst, nxt_after, prv_burst, prv_after, nxt_full;
    logic          sel_next;
    logic [SW-1:0] nxt_next;
    logic [WW-1:0] prv_next;

    assign ge_start = d2_ts >= start_reg;
    assign le_end   = d2_ts <= end_reg;
    assign in_burst = d2_phase < width_reg;
    assign hit      = (in_burst ? d2_slot : d2_phase) < ONE;

    assign t_x     = XW'(d2_t);
    assign p_x     = t_x - XW'(d2_phase);
    assign base_x  = t_x - XW'(d2_slot);    // period start + slot start
    assign start_x = XW'(start_reg);

    assign nxt_burst = start_x + ((base_x + XW'(spc_eff) + HALF_X) >> FRAC_BITS);
    assign nxt_after = start_x + ((p_x + XW'(per_eff) + HALF_X) >> FRAC_BITS);
    assign prv_burst = start_x + ((base_x + HALF_X) >> FRAC_BITS);
    // round(p + width - one): may reach -1 when the width is under half a step
    assign prv_after = start_x + ((p_x + XW'(width_reg) + HALF_X) >> FRAC_BITS) - XW'(1);

    always_comb
    begin
        sel_next = ge_start && le_end && hit;

        priority if (d2_ts <= start_reg)
            nxt_full = start_x;
        else if (!le_end)
            nxt_full = XW'(pbss_pkg::NO_NEXT);
        else if (in_burst && hit)
            nxt_full = XW'(d2_ts);
        else if (in_burst)
            nxt_full = nxt_burst;
        else
            nxt_full = nxt_after;

        nxt_next = (nxt_full > XW'(pbss_pkg::NO_NEXT)) ? pbss_pkg::NO_NEXT
                                                       : nxt_full[SW-1:0];

        priority if (!ge_start)
            prv_next = pbss_pkg::NO_PREV;
        else if (d2_ts >= end_reg)
            prv_next = WW'(end_reg);
        else if (in_burst)
            prv_next = prv_burst[WW-1:0];
        else
            prv_next = prv_after[WW-1:0];
    end

    logic          sel_reg;
    logic [SW-1:0] nxt_reg;
    logic [WW-1:0] prv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg <= sel_next;
            nxt_reg <= nxt_next;
            prv_reg <= prv_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign selected      = sel_reg;
    assign next_step     = nxt_reg;
    assign previous_step = prv_reg;

endmodule

// ===== rtl/pbss_checker.sv =====
// Port-level checker for the periodic burst step selector, with its bind.
`include "periodic_burst_step_selector_assert.svh"

module pbss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        selected,
    input logic [30:0] next_step,
    input logic [31:0] previous_step
);

    `PBSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_step) && $stable(previous_step) && $stable(selected), "stalled result word changed")
    `PBSS_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready, "input stalled while output side is free")
    `PBSS_ASSERT_NOW(a_none_unsel, out_valid && previous_step == pbss_pkg::NO_PREV, !selected, "step with no previous reported as selected")

endmodule

bind periodic_burst_step_selector pbss_checker u_pbss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .selected      (selected),
    .next_step     (next_step),
    .previous_step (previous_step)
);

// ===== dv/periodic_burst_step_selector_tb.sv =====
// Self-checking testbench for the periodic burst step selector.
module periodic_burst_step_selector_tb;

    localparam int FRAC = 8;
    localparam longint unsigned ONE  = 64'd1 << FRAC;
    localparam longint unsigned HALF = 64'd1 << (FRAC - 1);
    // Drain wait: the register stages of the pipe, rounded up for margin.
    localparam int PIPE_DEPTH = 1 + 31 + FRAC + 32 + 1 + 10;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [30:0] timestep;
    logic        out_valid;
    logic        out_ready;
    logic        selected;
    logic [30:0] next_step;
    logic [31:0] previous_step;

    typedef struct packed {
        logic        sel;
        logic [30:0] nxt;
        logic [31:0] prv;
    } answer_t;

    // Local copy of the schedule registers.
    longint unsigned win_start, win_end, per_len, spc_len, bw_len;

    answer_t pending_answers[$];
    int      err_count;
    int      words_sent;
    int      words_checked;
    int      sel_hits;
    longint  cycle_count;
    bit      hold_out;
    int      stall_left;

    periodic_burst_step_selector #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .timestep(timestep),
        .out_valid(out_valid), .out_ready(out_ready),
        .selected(selected), .next_step(next_step), .previous_step(previous_step)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Schedule predictor: classify one timestep against the current registers.
    function automatic answer_t classify_step(logic [30:0] ts_in);
        longint unsigned ts, per, spc, t, p, tt, r, rem, nxt, u;
        longint prv;
        bit in_burst;
        answer_t a;
        ts = ts_in;
        per = (per_len == 0) ? ONE : per_len;
        spc = (spc_len == 0) ? ONE : spc_len;
        t = 0; p = 0; tt = 0; r = 0;
        in_burst = 0;
        a.sel = 1'b0;
        if (ts >= win_start)
        begin
            t = ((ts - win_start) << FRAC) + HALF;
            p = (t / per) * per;
            tt = t - p;
            in_burst = tt < bw_len;
            if (in_burst)
                r = (tt / spc) * spc;
        end
        if (ts >= win_start && ts <= win_end)
        begin
            rem = in_burst ? tt - r : tt;
            if (rem < ONE)
                a.sel = 1'b1;
        end
        if (ts <= win_start)
            nxt = win_start;
        else if (ts > win_end)
            nxt = 64'h7FFF_FFFF;
        else if (in_burst)
            nxt = (tt - r < ONE) ? ts : win_start + ((p + r + spc + HALF) >> FRAC);
        else
            nxt = win_start + ((p + per + HALF) >> FRAC);
        if (nxt > 64'h7FFF_FFFF)
            nxt = 64'h7FFF_FFFF;
        if (ts < win_start)
            prv = -64'sd2147483648;
        else if (ts >= win_end)
            prv = longint'(win_end);
        else if (in_burst)
            prv = longint'(win_start + ((p + r + HALF) >> FRAC));
        else
        begin
            u = (p + bw_len + HALF) >> FRAC;
            prv = longint'(win_start + u) - 1;
        end
        a.nxt = nxt[30:0];
        a.prv = prv[31:0];
        return a;
    endfunction

    // No gap half the time, mostly short gaps otherwise, sometimes long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result checker: compare each accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked <= words_checked + 1;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result word with no prediction waiting", $time);
                err_count <= err_count + 1;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (exp_a.sel) sel_hits <= sel_hits + 1;
                if (selected !== exp_a.sel)
                begin
                    $display("%0t: selected expected %0d actual %0d",
                             $time, exp_a.sel, selected);
                    err_count <= err_count + 1;
                end
                if (next_step !== exp_a.nxt)
                begin
                    $display("%0t: next_step expected %0d actual %0d",
                             $time, exp_a.nxt, next_step);
                    err_count <= err_count + 1;
                end
                if (previous_step !== exp_a.prv)
                begin
                    $display("%0t: previous_step expected %0d actual %0d",
                             $time, $signed(exp_a.prv), $signed(previous_step));
                    err_count <= err_count + 1;
                end
            end
        end
    end

    // Receiver back-pressure, changed at the falling edge; a stall lasts a gap.
    always @(negedge clk)
    begin
        if (!rst_n || hold_out)
        begin
            out_ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap();
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Write one register while the pipe is empty.
    task automatic write_reg(pbss_pkg::cfg_reg_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            pbss_pkg::REG_START_STEP:    win_start = val[30:0];
            pbss_pkg::REG_END_STEP:      win_end   = val[30:0];
            pbss_pkg::REG_PERIOD_LEN:    per_len   = val;
            pbss_pkg::REG_BURST_SPACING: spc_len   = val;
            pbss_pkg::REG_BURST_WIDTH:   bw_len    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_schedule(logic [30:0] s, logic [30:0] e, logic [31:0] per,
                                logic [31:0] spc, logic [31:0] bw);
        write_reg(pbss_pkg::REG_START_STEP, {1'b0, s});
        write_reg(pbss_pkg::REG_END_STEP, {1'b0, e});
        write_reg(pbss_pkg::REG_PERIOD_LEN, per);
        write_reg(pbss_pkg::REG_BURST_SPACING, spc);
        write_reg(pbss_pkg::REG_BURST_WIDTH, bw);
    endtask

    // Send one timestep word; valid stays up between back-to-back words.
    task automatic send_step(logic [30:0] ts, bit use_gaps);
        int g;
        g = use_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        timestep <= ts;
        do @(posedge clk); while (!in_ready);
        pending_answers.push_back(classify_step(ts));
        words_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every prediction is consumed and the pipe has drained.
    task automatic drain_pipe();
        drop_valid();
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // Random timestep: near the window edges, inside the window, or anywhere.
    function automatic logic [30:0] pick_step();
        int roll;
        longint unsigned v;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            v = win_start + $urandom_range(0, 6) - 3;
        else if (roll < 25)
            v = win_end + $urandom_range(0, 6) - 3;
        else if (roll < 80 && win_end >= win_start)
            v = win_start + ($urandom() % (win_end - win_start + 1));
        else
            v = $urandom() & 32'h7FFF_FFFF;
        return v[30:0];
    endfunction

    task automatic test_reset_schedule();
        send_step(31'd0, 0);
        send_step(31'd1, 0);
        send_step(31'h7FFF_FFFF, 0);
        send_step(31'h7FFF_FFFE, 0);
        send_step(31'h5555_5555, 0);
        send_step(31'h2AAA_AAAA, 0);
        drain_pipe();
    endtask

    task automatic test_directed_cases();
        // Bursts of 3 steps spaced 2.5 apart every 10.25 steps, window 100..1000.
        set_schedule(31'd100, 31'd1000, 32'd2624, 32'd640, 32'd1536);
        send_step(31'd0, 0);          // before the window
        send_step(31'd100, 0);        // at the start
        send_step(31'd101, 0);        // inside a burst, between steps
        send_step(31'd103, 0);        // rounding up within a burst
        send_step(31'd107, 0);        // after a burst
        send_step(31'd1000, 0);       // at the end
        send_step(31'd1001, 0);       // after the window
        send_step(31'h7FFF_FFFF, 0);
        drain_pipe();
        // Start past end, zero period and spacing, width below one step.
        set_schedule(31'd50, 31'd10, 32'd0, 32'd0, 32'd0);
        send_step(31'd5, 0);
        send_step(31'd50, 0);
        send_step(31'd60, 0);
        drain_pipe();
        // Start at zero with tiny width: previous step can go to -1.
        set_schedule(31'd0, 31'h7FFF_FFFF, 32'd1024, 32'd256, 32'd64);
        send_step(31'd1, 0);
        send_step(31'd4, 0);
        drain_pipe();
        // Next step saturation near the top of the range.
        set_schedule(31'h7FFF_FF00, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'd256);
        send_step(31'h7FFF_FF00, 0);
        send_step(31'h7FFF_FF01, 0);
        send_step(31'h7FFF_FFFF, 0);
        drain_pipe();
    endtask

    task automatic random_schedule();
        logic [31:0] per, spc, bw;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            per = $urandom(); spc = $urandom(); bw = $urandom();
        end
        else
        begin
            per = $urandom_range(256, 256 * 64);
            spc = $urandom_range(128, 256 * 8);
            bw  = $urandom_range(0, per + 512);
        end
        set_schedule(31'($urandom_range(0, 5000)), $urandom_range(0, 1) ?
                     31'h7FFF_FFFF : 31'($urandom_range(0, 40000)), per, spc, bw);
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            random_schedule();
            for (int i = 0; i < per_phase; i++)
                send_step(pick_step(), 1);
            drain_pipe();
        end
    endtask

    // Back-to-back words, then the sender waits for every result.
    task automatic test_full_rate_pause();
        hold_out = 1;
        for (int i = 0; i < 200; i++)
            send_step(pick_step(), 0);
        drop_valid();
        while (pending_answers.size() != 0) @(posedge clk);
        hold_out = 0;
        for (int i = 0; i < 50; i++)
            send_step(pick_step(), 1);
        drain_pipe();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pbss_pkg::REG_START_STEP;
        cfg_data = '0;
        in_valid = 1'b0;
        timestep = '0;
        out_ready = 1'b1;
        hold_out = 0;
        stall_left = 0;
        err_count = 0;
        words_sent = 0;
        words_checked = 0;
        sel_hits = 0;
        cycle_count = 0;
        win_start = 0;
        win_end = 64'h7FFF_FFFF;
        per_len = ONE;
        spc_len = ONE;
        bw_len = ONE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_schedule();
        test_directed_cases();
        test_full_rate_pause();
        test_random_phases(34, 50);
        drain_pipe();

        $display("Sent %0d timestep words over many schedules; %0d results checked,",
                 words_sent, words_checked);
        $display("%0d of them selected steps, %0d mismatches.", sel_hits, err_count);
        if (err_count == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
